// ----- rtl/rmsn_pkg.sv -----
// Package: shared types and constants for the RMS row normalizer.
`default_nettype none
package rmsn_pkg;
   localparam int MAX_ROW_DEFAULT = 64;
   localparam int CSR_IDX_W       = 1;
   localparam int CSR_DATA_W      = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON    = 1'b1;
   localparam logic [6:0]  ROW_LENGTH_RESET = 7'd64;
   localparam logic [23:0] EPSILON_RESET    = 24'd17;

   typedef struct packed {
      logic signed [15:0] x_value;
      logic signed [15:0] weight_value;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] y_value;
      logic [31:0]        inv_rms;
      logic               row_end;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV_MEAN, ST_DIV_RECIP, ST_SQRT, ST_EMIT_RD, ST_EMIT_MUL1,
      ST_EMIT_MUL2
   } state_type;
endpackage
`default_nettype wire

// ----- rtl/rms_normalize_row.sv -----
// RMS row normalizer: buffers a row, forms 1/rms, emits scaled elements.
// Usage:
//   Pulse start with req_word when busy is low; one element (x, weight) is
//   taken per accepted word, one cycle each. Words that do not close the row
//   produce no result and busy stays low.
//   On the word that completes the row (row_length, 0 acts as 1, above
//   MAX_ROW acts as MAX_ROW) busy rises and a shared shift/subtract unit runs:
//   mean division (37 steps), 2^56/(mean + epsilon) division (57 steps) and
//   an integer square root (29 steps). Then each element is read and scaled
//   through ST_EMIT_RD, ST_EMIT_MUL1 and ST_EMIT_MUL2, one rsp_word strobed by
//   rsp_valid per element, row_end marking the last. When mean plus epsilon
//   is zero the reciprocal division and the square root are skipped. The last
//   result is strobed in the first cycle with busy low.
//   The receiver cannot stall; every result is shown for exactly one cycle.
//   csr_we writes row_length (index 0) or epsilon (index 1) immediately.
//   Reset (synchronous) restores row_length 64, epsilon 17, clears sum and
//   count; the element stores need no clearing.
`default_nettype none
module rms_normalize_row #(
   parameter int MAX_ROW = rmsn_pkg::MAX_ROW_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire rmsn_pkg::req_word_type        req_word,
   output logic                               rsp_valid,
   output rmsn_pkg::rsp_word_type             rsp_word,
   input  wire logic                          csr_we,
   input  wire logic [rmsn_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rmsn_pkg::CSR_DATA_W-1:0] csr_data
);
   import rmsn_pkg::*;
   localparam int AW = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;

   // configuration
   logic [6:0]  row_length_ff;
   logic [23:0] epsilon_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= ROW_LENGTH_RESET;
         epsilon_ff    <= EPSILON_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ROW_LENGTH: row_length_ff <= csr_data[6:0];
            CSR_EPSILON:    epsilon_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   logic [6:0] eff_len;
   always_comb begin
      if (row_length_ff == 7'd0) eff_len = 7'd1;
      else if (row_length_ff > 7'(MAX_ROW)) eff_len = 7'(MAX_ROW);
      else eff_len = row_length_ff;
   end

   state_type   state_ff, state_in;
   logic [6:0]  count_ff, count_in;
   logic [36:0] sum_ff, sum_in;
   logic [63:0] rem_ff, rem_in;     // remainder / sqrt radicand
   logic [63:0] quo_ff, quo_in;     // quotient / sqrt result
   logic [63:0] dvd_ff, dvd_in;     // dividend shift / sqrt bit
   logic [6:0]  step_ff, step_in;
   logic [31:0] inv_ff, inv_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [47:0] prod_ff, prod_in;
   logic        neg_ff, neg_in;
   logic [15:0] aw_ff, aw_in;
   logic        rsp_valid_in;
   rsp_word_type rsp_in;

   logic accept;
   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // element stores
   logic [AW-1:0] wr_addr;
   logic [15:0] x_rd, w_rd;
   assign wr_addr = (count_ff >= 7'(MAX_ROW)) ? AW'(MAX_ROW - 1) : count_ff[AW-1:0];
   rmsn_ram #(.WIDTH(16), .DEPTH(MAX_ROW)) u_x_ram (
      .clock, .wr_en(accept), .wr_addr, .wr_data(req_word.x_value),
      .rd_addr(idx_in), .rd_data(x_rd));
   rmsn_ram #(.WIDTH(16), .DEPTH(MAX_ROW)) u_w_ram (
      .clock, .wr_en(accept), .wr_addr, .wr_data(req_word.weight_value),
      .rd_addr(idx_in), .rd_data(w_rd));

   logic [15:0] mx, ax, aw;
   assign mx = req_word.x_value[15] ? 16'(-req_word.x_value) : req_word.x_value;
   assign ax = x_rd[15] ? 16'(-x_rd) : x_rd;
   assign aw = w_rd[15] ? 16'(-w_rd) : w_rd;

   // shared shift/subtract unit
   logic [64:0] trial;
   logic [63:0] rem_sh;
   logic [63:0] mean_val;
   logic [63:0] sq_cand;
   logic [64:0] rnd;
   logic [32:0] sat_pos;
   logic [47:0] mul1;
   assign mean_val = quo_ff + 64'(epsilon_ff);

   always_comb begin
      state_in = state_ff; count_in = count_ff; sum_in = sum_ff;
      rem_in = rem_ff; quo_in = quo_ff; dvd_in = dvd_ff; step_in = step_ff;
      inv_in = inv_ff; idx_in = idx_ff; prod_in = prod_ff; neg_in = neg_ff;
      aw_in = aw_ff; rsp_valid_in = 1'b0; rsp_in = rsp_word;
      rem_sh = '0; trial = '0; sq_cand = '0; rnd = '0; sat_pos = '0; mul1 = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sum_in   = sum_ff + 37'(32'(mx) * 32'(mx));
               count_in = 7'(wr_addr) + 7'd1;
               if (count_in >= eff_len) begin
                  // divide sum by count, MSB first
                  rem_in = '0; quo_in = 64'(sum_in); step_in = 7'd37;
                  state_in = ST_DIV_MEAN;
               end
            end
         end
         ST_DIV_MEAN: begin
            rem_sh = {rem_ff[62:0], quo_ff[36]};
            trial  = {1'b0, rem_sh} - 65'(count_ff);
            quo_in = {27'd0, quo_ff[35:0], ~trial[64]};
            rem_in = trial[64] ? rem_sh : trial[63:0];
            step_in = step_ff - 7'd1;
            if (step_ff == 7'd1) state_in = ST_DIV_RECIP;
            if (state_in == ST_DIV_RECIP) begin
               // quo_in holds mean; epsilon is added via mean_val in ST_DIV_RECIP
               dvd_in = 64'd1 << 56;
               step_in = 7'd57;
               rem_in = '0;
            end
         end
         ST_DIV_RECIP: begin
            if (mean_val == 64'd0 && step_ff == 7'd57) begin
               inv_in = 32'hFFFF_FFFF; idx_in = '0; state_in = ST_EMIT_RD;
            end else begin
               rem_sh = {rem_ff[62:0], dvd_ff[56]};
               trial  = {1'b0, rem_sh} - {1'b0, mean_val};
               dvd_in = {dvd_ff[62:0], ~trial[64]};
               rem_in = trial[64] ? rem_sh : trial[63:0];
               step_in = step_ff - 7'd1;
               if (step_ff == 7'd1) begin
                  // quotient sits in dvd_in low bits; start sqrt
                  rem_in = {7'd0, dvd_in[56:0]};
                  quo_in = '0;
                  dvd_in = 64'd1 << 56;
                  step_in = 7'd29;
                  state_in = ST_SQRT;
               end
            end
         end
         ST_SQRT: begin
            sq_cand = quo_ff + dvd_ff;
            if (rem_ff >= sq_cand) begin
               rem_in = rem_ff - sq_cand;
               quo_in = (quo_ff >> 1) + dvd_ff;
            end else begin
               quo_in = quo_ff >> 1;
            end
            dvd_in = dvd_ff >> 2;
            step_in = step_ff - 7'd1;
            if (step_ff == 7'd1) begin
               inv_in = (quo_in[63:32] != 0) ? 32'hFFFF_FFFF : quo_in[31:0];
               idx_in = '0;
               state_in = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: state_in = ST_EMIT_MUL1;   // read data lands
         ST_EMIT_MUL1: begin
            mul1 = 48'(ax) * 48'(inv_ff);
            prod_in = mul1;
            neg_in = x_rd[15] ^ w_rd[15];
            aw_in = aw;
            state_in = ST_EMIT_MUL2;
         end
         ST_EMIT_MUL2: begin
            rnd = (65'(prod_ff) * 65'(aw_ff) + (65'd1 << 27)) >> 28;
            if (neg_ff) begin
               sat_pos = (rnd > 65'd32768) ? 33'd32768 : rnd[32:0];
               rsp_in.y_value = 16'(17'h10000 - 17'(sat_pos));
            end else begin
               sat_pos = (rnd > 65'd32767) ? 33'd32767 : rnd[32:0];
               rsp_in.y_value = sat_pos[15:0];
            end
            rsp_in.inv_rms = inv_ff;
            rsp_in.row_end = (7'(idx_ff) + 7'd1 == count_ff);
            rsp_valid_in = 1'b1;
            if (rsp_in.row_end) begin
               state_in = ST_IDLE; sum_in = '0; count_in = '0;
            end else begin
               idx_in = idx_ff + AW'(1);
               state_in = ST_EMIT_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         sum_ff   <= '0;
         rsp_valid <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         rsp_valid <= rsp_valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in; quo_ff <= quo_in; dvd_ff <= dvd_in; step_ff <= step_in;
      inv_ff <= inv_in; prod_ff <= prod_in; neg_ff <= neg_in; aw_ff <= aw_in;
      rsp_word <= rsp_in;
   end
endmodule
`default_nettype wire

// ----- rtl/rmsn_ram.sv -----
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`default_nettype none
module rmsn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- sim/rms_normalize_row_checker.sv -----
// Checker for the RMS row normalizer: tracks config, predicts rows, compares results.
`timescale 1ns / 100ps
module rms_normalize_row_checker
   import rmsn_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  busy,
   input  wire req_word_type          req_word,
   input  wire logic                  rsp_valid,
   input  wire rsp_word_type          rsp_word,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output int                         error_count,
   output int                         pending_count,
   output int                         row_count,
   output int                         word_count
);
   logic [6:0]  row_len_reg;
   logic [23:0] eps_reg;
   logic [15:0] x_buf [64];
   logic [15:0] w_buf [64];
   logic [36:0] sq_sum;
   int          held;
   rsp_word_type scaled_q[$];

   function automatic logic [63:0] isqrt64(input logic [63:0] a);
      logic [63:0] res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > a) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (a >= res + bitv) begin
            a   = a - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic [15:0] abs16(input logic [15:0] v);
      return v[15] ? 16'(17'h10000 - {1'b0, v}) : v;
   endfunction

   // close the row: compute the factor and queue one word per held element
   task automatic close_row();
      logic [63:0]  mean, r, mag, rnd;
      logic [31:0]  inv;
      rsp_word_type w;
      mean = sq_sum / held + eps_reg;
      if (mean == 0) inv = '1;
      else begin
         r   = isqrt64((64'd1 << 56) / mean);
         inv = (r > 64'hFFFF_FFFF) ? '1 : r[31:0];
      end
      for (int k = 0; k < held; k++) begin
         mag = 64'(abs16(x_buf[k])) * inv;
         mag = mag * abs16(w_buf[k]);
         rnd = (mag + (64'd1 << 27)) >> 28;
         if (x_buf[k][15] != w_buf[k][15]) begin
            if (rnd > 32768) rnd = 32768;
            w.y_value = 16'(17'h10000 - rnd[16:0]);
         end else begin
            if (rnd > 32767) rnd = 32767;
            w.y_value = rnd[15:0];
         end
         w.inv_rms = inv;
         w.row_end = (k == held - 1);
         scaled_q.push_back(w);
      end
      row_count++;
      sq_sum = 0;
      held   = 0;
   endtask

   always @(posedge clock) begin
      rsp_word_type exp_w;
      int           eff_len;
      logic [15:0]  ax;
      if (reset) begin
         row_len_reg <= ROW_LENGTH_RESET;
         eps_reg     <= EPSILON_RESET;
         sq_sum      = 0;
         held        = 0;
         scaled_q.delete();
      end else begin
         // result side
         if (rsp_valid) begin
            if (scaled_q.size() == 0) begin
               $display("%0t: unexpected word: actual %p", $time, rsp_word);
               error_count++;
            end else begin
               exp_w = scaled_q.pop_front();
               if (rsp_word.y_value !== exp_w.y_value) begin
                  $display("%0t: y_value expected %0d actual %0d", $time,
                           exp_w.y_value, rsp_word.y_value);
                  error_count++;
               end
               if (rsp_word.inv_rms !== exp_w.inv_rms) begin
                  $display("%0t: inv_rms expected %h actual %h", $time,
                           exp_w.inv_rms, rsp_word.inv_rms);
                  error_count++;
               end
               if (rsp_word.row_end !== exp_w.row_end) begin
                  $display("%0t: row_end expected %b actual %b", $time,
                           exp_w.row_end, rsp_word.row_end);
                  error_count++;
               end
            end
         end
         // input side
         if (start && !busy) begin
            eff_len = (row_len_reg == 0) ? 1 : (row_len_reg > 64) ? 64 : row_len_reg;
            if (held >= 64) held = 63;
            x_buf[held] = req_word.x_value;
            w_buf[held] = req_word.weight_value;
            ax = abs16(req_word.x_value);
            sq_sum = sq_sum + 37'(32'(ax) * 32'(ax));
            held++;
            word_count++;
            if (held >= eff_len) close_row();
         end
         // register writes
         if (csr_we) begin
            if (csr_index == CSR_ROW_LENGTH) row_len_reg <= csr_data[6:0];
            else if (csr_index == CSR_EPSILON) eps_reg <= csr_data;
         end
      end
      pending_count = scaled_q.size();
   end

   initial begin
      error_count   = 0;
      pending_count = 0;
      row_count     = 0;
      word_count    = 0;
   end
endmodule

// ----- sim/rms_normalize_row_tb.sv -----
// Top of the RMS row normalizer testbench: stimulus, config phases, verdict.
`timescale 1ns / 100ps
module rms_normalize_row_tb;
   import rmsn_pkg::*;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  start = 0;
   logic                  busy;
   req_word_type          req_word = '0;
   logic                  rsp_valid;
   rsp_word_type          rsp_word;
   logic                  csr_we = 0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   int error_count, pending_count, row_count, word_count;
   int cycle_count = 0;
   int idle_pct = 0;

   localparam int CYCLE_LIMIT = 600000;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   rms_normalize_row uut (
      .clock, .reset, .start, .busy, .req_word, .rsp_valid, .rsp_word,
      .csr_we, .csr_index, .csr_data
   );

   rms_normalize_row_checker chk (
      .clock, .reset, .start, .busy, .req_word, .rsp_valid, .rsp_word,
      .csr_we, .csr_index, .csr_data,
      .error_count, .pending_count, .row_count, .word_count
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // send one word; start stays high across back-to-back words
   task automatic send_word(input logic [15:0] xv, input logic [15:0] wv);
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start    <= 1;
      req_word <= '{x_value: xv, weight_value: wv};
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // drop start and wait until every expected word has arrived, plus slack
   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (pending_count != 0 || busy) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // one write cycle, then a quiet cycle so back-to-back writes never collide
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [23:0] val);
      csr_we    <= 1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_we    <= 0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] rand_x();
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 8191) - 4096);
         2: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
         default: return 16'($urandom_range(0, 255) - 128);
      endcase
   endfunction

   task automatic random_rows(input int words, input int pct, input int max_len);
      int len;
      idle_pct = pct;
      while (words > 0) begin
         len = $urandom_range(1, max_len);
         if (len > words) len = words;
         write_reg(CSR_ROW_LENGTH, 24'(len));
         write_reg(CSR_EPSILON,
                   $urandom_range(3) == 0 ? 24'($urandom) : 24'($urandom_range(0, 64)));
         for (int i = 0; i < len; i++) send_word(rand_x(), rand_x());
         words -= len;
         drain();
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset config, full 64-word row of extremes
      for (int i = 0; i < 64; i++)
         send_word(i[0] ? 16'h8000 : 16'h7FFF, i[1] ? 16'h8000 : 16'h7FFF);
      drain();
      // zero mean with zero epsilon saturates the factor
      write_reg(CSR_ROW_LENGTH, 24'd2);
      write_reg(CSR_EPSILON, 24'd0);
      send_word(16'h0000, 16'h7FFF);
      send_word(16'h0000, 16'h8000);
      drain();
      // row_length 0 acts as 1, max epsilon
      write_reg(CSR_ROW_LENGTH, 24'd0);
      write_reg(CSR_EPSILON, 24'hFFFFFF);
      send_word(16'h1000, 16'hF000);
      drain();
      // above MAX_ROW acts as MAX_ROW; tiny values
      write_reg(CSR_ROW_LENGTH, 24'd127);
      write_reg(CSR_EPSILON, 24'd1);
      for (int i = 0; i < 64; i++) send_word(16'h0001, 16'hFFFF);
      drain();
      // length shortened mid-row closes on the next word
      write_reg(CSR_ROW_LENGTH, 24'd5);
      send_word(16'h0800, 16'h1000);
      send_word(16'hF800, 16'h1000);
      send_word(16'h0400, 16'hE000);
      start <= 0;
      @(posedge clock);
      write_reg(CSR_ROW_LENGTH, 24'd2);
      send_word(16'h0100, 16'h1000);
      drain();

      // random phases: no idle, sender idle, mixed lengths up to 64, single-word rows
      random_rows(20, 0, 8);
      random_rows(20, 47, 8);
      random_rows(25, 6, 64);
      random_rows(5, 0, 1);
      drain();
      repeat (200) @(posedge clock);

      $display("covered %0d words in %0d rows across lengths 1..64 and eps extremes",
               word_count, row_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d errors, %0d words missing", error_count, pending_count);
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

// ----- rms_normalize_row.f -----
rtl/rmsn_pkg.sv
rtl/rmsn_ram.sv
rtl/rms_normalize_row.sv
sim/rms_normalize_row_checker.sv
sim/rms_normalize_row_tb.sv
